// ----- rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared definitions for the double-ended queue
// Sizes, operation and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package dq_pkg;

   // Store geometry (2 to 64 slots)
   localparam int DEPTH  = 64;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW     = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OCC_W  = 7;
   localparam int CODE_W = 3;

   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   // Operation codes carried on req_tuser
   typedef enum logic [CODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_DUMP       = 3'd4
   } op_type;

   // Status codes carried on rsp_tuser
   typedef enum logic [CODE_W-1:0] {
      ST_OK        = 3'd0,
      ST_LISTED    = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_UNDERFLOW = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   // Sequencer state
   typedef enum logic {
      SEQ_IDLE,
      SEQ_DUMP
   } seq_type;

endpackage

// ----- rtl/dq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// Read data holds until the next read.
// ----------------------------------------------------------------------------
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// A push or pop result is registered and appears the cycle after its beat is accepted.
// Throughput: one push or pop per cycle while rsp is taken (output register).
// Dump: one result per cycle while rsp is taken, set by the single RAM read port;
// the first passes the RAM read and output registers; next beat after the last.
// Reset (synchronous): deque empty, head at slot 0; the store is not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// Circular store in a RAM with a head pointer and a fill count. Pushes and
// pops update the pointers; a dump walks the store front to rear.
// ----------------------------------------------------------------------------
module double_ended_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] element, [38:32] occupancy, [39] zero
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast    // last result of the request
);

   localparam int AW = dq_pkg::AW;
   localparam int CW = dq_pkg::CW;

   // Control registers
   dq_pkg::seq_type       state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         rd_idx_ff, rd_idx_in;
   logic [CW-1:0]         ld_idx_ff, ld_idx_in;
   logic                  rd_pend_ff, rd_pend_in;

   // Output register
   logic                  out_valid_ff, out_valid_in;
   dq_pkg::status_type    out_status_ff, out_status_in;
   logic [31:0]           out_elem_ff, out_elem_in;
   logic [CW-1:0]         out_occ_ff, out_occ_in;
   logic                  out_last_ff, out_last_in;

   // RAM ports
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [31:0]           rd_data;

   logic                  out_free;
   logic                  accept;
   logic                  dump_load;
   logic                  dump_last;
   logic                  issue;

   // Slot of head plus offset, wrapped into the store
   function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offs);
      logic [CW:0] sum;
      sum = (CW + 1)'(base) + (CW + 1)'(offs);
      if (sum >= (CW + 1)'(dq_pkg::DEPTH)) begin
         sum = sum - (CW + 1)'(dq_pkg::DEPTH);
      end
      return AW'(sum);
   endfunction

   dq_ram #(
      .WIDTH (dq_pkg::DATA_W),
      .DEPTH (dq_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == dq_pkg::SEQ_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::SEQ_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         ld_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         ld_idx_ff    <= ld_idx_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_elem_ff   <= out_elem_in;
      out_occ_ff    <= out_occ_in;
      out_last_ff   <= out_last_in;
   end

   // Next state, pointer updates and result loading
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      ld_idx_in     = ld_idx_ff;
      rd_pend_in    = rd_pend_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_elem_in   = out_elem_ff;
      out_occ_in    = out_occ_ff;
      out_last_in   = out_last_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      rd_en         = 1'b0;
      rd_addr       = wrap_slot(head_ff, rd_idx_ff);
      dump_load     = 1'b0;
      dump_last     = 1'b0;
      issue         = 1'b0;

      unique case (state_ff)
         dq_pkg::SEQ_IDLE: begin
            if (accept) begin
               // every defined code but a dump of a non-empty deque yields a single result beat
               out_elem_in = '0;
               out_last_in = 1'b1;
               out_occ_in  = count_ff;
               case (dq_pkg::op_type'(req_tuser))
                  dq_pkg::OP_PUSH_FRONT: begin
                     out_valid_in = 1'b1;
                     if (count_ff >= dq_pkg::FULL_CNT) begin
                        out_status_in = dq_pkg::ST_OVERFLOW;
                     end else begin
                        head_in       = (head_ff == '0) ? dq_pkg::LAST_SLOT
                                                        : head_ff - 1'b1;
                        wr_en         = 1'b1;
                        wr_addr       = head_in;
                        count_in      = count_ff + 1'b1;
                        out_status_in = dq_pkg::ST_OK;
                        out_occ_in    = count_in;
                     end
                  end
                  dq_pkg::OP_PUSH_REAR: begin
                     out_valid_in = 1'b1;
                     if (count_ff >= dq_pkg::FULL_CNT) begin
                        out_status_in = dq_pkg::ST_OVERFLOW;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = wrap_slot(head_ff, count_ff);
                        count_in      = count_ff + 1'b1;
                        out_status_in = dq_pkg::ST_OK;
                        out_occ_in    = count_in;
                     end
                  end
                  dq_pkg::OP_POP_FRONT: begin
                     out_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        out_status_in = dq_pkg::ST_UNDERFLOW;
                     end else begin
                        head_in       = (head_ff == dq_pkg::LAST_SLOT) ? '0
                                                                      : head_ff + 1'b1;
                        count_in      = count_ff - 1'b1;
                        out_status_in = dq_pkg::ST_OK;
                        out_occ_in    = count_in;
                     end
                  end
                  dq_pkg::OP_POP_REAR: begin
                     out_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        out_status_in = dq_pkg::ST_UNDERFLOW;
                     end else begin
                        count_in      = count_ff - 1'b1;
                        out_status_in = dq_pkg::ST_OK;
                        out_occ_in    = count_in;
                     end
                  end
                  dq_pkg::OP_DUMP: begin
                     if (count_ff == '0) begin
                        out_valid_in  = 1'b1;
                        out_status_in = dq_pkg::ST_EMPTY;
                     end else begin
                        state_in   = dq_pkg::SEQ_DUMP;
                        rd_idx_in  = '0;
                        ld_idx_in  = '0;
                        rd_pend_in = 1'b0;
                     end
                  end
                  default: begin
                     // undefined codes are dropped without a result
                  end
               endcase
            end
         end
         dq_pkg::SEQ_DUMP: begin
            // move the element held at the RAM output into the result register
            dump_load = rd_pend_ff && out_free;
            dump_last = (ld_idx_ff + CW'(1)) == count_ff;
            if (dump_load) begin
               out_valid_in  = 1'b1;
               out_status_in = dq_pkg::ST_LISTED;
               out_elem_in   = rd_data;
               out_occ_in    = count_ff;
               out_last_in   = dump_last;
               ld_idx_in     = ld_idx_ff + 1'b1;
               rd_pend_in    = 1'b0;
               if (dump_last) begin
                  state_in = dq_pkg::SEQ_IDLE;
               end
            end
            // fetch the next slot once the read data register is free
            issue = (rd_idx_ff < count_ff) && (!rd_pend_ff || dump_load);
            if (issue) begin
               rd_en      = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
         end
         default: begin
            state_in = dq_pkg::SEQ_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, dq_pkg::OCC_W'(out_occ_ff), out_elem_ff};

`ifndef SYNTHESIS
   // fill count never exceeds the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dq_pkg::FULL_CNT)
      else $error("fill count above depth");

   // a pending read always runs ahead of the delivered elements
   a_pend_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dq_pkg::SEQ_DUMP && rd_pend_ff) |-> (rd_idx_ff > ld_idx_ff))
      else $error("dump read and load out of order");

   // pointers stay put while the store is walked
   a_dump_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dq_pkg::SEQ_DUMP) |=> ($stable(head_ff) && $stable(count_ff)))
      else $error("pointers moved during dump");

   // the final listed element ends the dump
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (dump_load && dump_last) |=> (state_ff == dq_pkg::SEQ_IDLE && rsp_tlast))
      else $error("dump did not end on last element");

   // no write to the store during a dump
   a_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dq_pkg::SEQ_DUMP) |-> !wr_en)
      else $error("store written during dump");
`endif

endmodule

// ----- tb/double_ended_queue_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_test: self-checking bench for the bounded deque
// Drives push, pop, dump and unused operation beats with random gaps and
// response back-pressure. A shadow deque predicts every status, listed
// element, occupancy and last flag, and the result stream is checked in order.
// ----------------------------------------------------------------------------
module double_ended_queue_test;

   localparam int          HALF_PERIOD  = 10;
   localparam int          RESET_CYCLES = 8;
   localparam int          ITEM_TARGET  = 360;   // request beats, directed included
   localparam int          GAP_PERCENT  = 24;
   localparam int          STALL_LIMIT  = 2000;  // cycles with no beat on either side
   localparam int          TAIL_CYCLES  = 16;
   localparam int          MAX_REPORTS  = 10;
   localparam int          MIXED_RUN    = 30;

   // Codes outside the operation set; the block drops them
   localparam logic [dq_pkg::CODE_W-1:0] OP_BAD_LO  = 3'd5;
   localparam logic [dq_pkg::CODE_W-1:0] OP_BAD_MID = 3'd6;
   localparam logic [dq_pkg::CODE_W-1:0] OP_BAD_HI  = 3'd7;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} bias_mode_type;

   typedef struct {
      dq_pkg::status_type        status;
      logic [dq_pkg::DATA_W-1:0] element;
      logic [dq_pkg::OCC_W-1:0]  occupancy;
      logic                      last;
   } deque_result_type;

   // Shadow deque and in-order store of predicted result beats
   class deque_scoreboard_type;
      logic [dq_pkg::DATA_W-1:0] slots [dq_pkg::DEPTH];
      int unsigned               head;
      int unsigned               fill;
      deque_result_type          pending [$];
      int unsigned               mismatches;
      int unsigned               beats_seen;

      function void push_expected(dq_pkg::status_type status,
                                  logic [dq_pkg::DATA_W-1:0] element,
                                  int unsigned occupancy, logic last);
         deque_result_type r;
         r.status    = status;
         r.element   = element;
         r.occupancy = dq_pkg::OCC_W'(occupancy);
         r.last      = last;
         pending.push_back(r);
      endfunction

      function void note_request(logic [dq_pkg::CODE_W-1:0] op,
                                 logic [dq_pkg::DATA_W-1:0] value);
         int unsigned i;
         case (op)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
               if (fill >= dq_pkg::DEPTH) begin
                  push_expected(dq_pkg::ST_OVERFLOW, '0, fill, 1'b1);
               end else begin
                  if (op == dq_pkg::OP_PUSH_FRONT) begin
                     head = (head + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
                     slots[head] = value;
                  end else begin
                     slots[(head + fill) % dq_pkg::DEPTH] = value;
                  end
                  fill++;
                  push_expected(dq_pkg::ST_OK, '0, fill, 1'b1);
               end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR: begin
               if (fill == 0) begin
                  push_expected(dq_pkg::ST_UNDERFLOW, '0, 0, 1'b1);
               end else begin
                  if (op == dq_pkg::OP_POP_FRONT)
                     head = (head + 1) % dq_pkg::DEPTH;
                  fill--;
                  push_expected(dq_pkg::ST_OK, '0, fill, 1'b1);
               end
            end
            dq_pkg::OP_DUMP: begin
               if (fill == 0)
                  push_expected(dq_pkg::ST_EMPTY, '0, 0, 1'b1);
               else
                  for (i = 0; i < fill; i++)
                     push_expected(dq_pkg::ST_LISTED, slots[(head + i) % dq_pkg::DEPTH],
                                   fill, (i + 1 == fill));
            end
            default: ;  // unused code: no result, no state change
         endcase
      endfunction

      function void check_response(logic [dq_pkg::CODE_W-1:0] status, logic [39:0] data,
                                   logic last);
         deque_result_type r;
         beats_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("beat %0d: unexpected result, status %0d data %h last %b",
                        beats_seen, status, data, last);
            return;
         end
         r = pending.pop_front();
         if (status !== r.status || data !== {1'b0, r.occupancy, r.element} ||
             last !== r.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $write("beat %0d: status %0d exp %0d, element %h exp %h, ",
                      beats_seen, status, r.status, data[31:0], r.element);
               $display("occupancy %0d exp %0d, pad %b exp 0, last %b exp %b",
                        data[38:32], r.occupancy, data[39], last, r.last);
            end
         end
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata  = '0;   // [31:0] value
   logic [2:0]        req_tuser  = '0;   // [2:0] operation
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [39:0]       rsp_tdata;         // [31:0] element, [38:32] occupancy, [39] zero
   logic [2:0]        rsp_tuser;         // [2:0] status
   logic              rsp_tlast;

   deque_scoreboard_type sb = new();
   logic              steady = 1'b0;     // no gaps on either side while set
   int unsigned       items_sent = 0;
   int unsigned       stall_cycles = 0;

   double_ended_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Response back-pressure
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= GAP_PERCENT);
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // Cycles since the last beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // One request beat, with optional idle cycles ahead of it
   task automatic send_request(input logic [dq_pkg::CODE_W-1:0] op,
                               input logic [dq_pkg::DATA_W-1:0] value);
      while (!steady && $urandom_range(0, 99) < GAP_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      sb.note_request(op, value);
      items_sent++;
   endtask

   function automatic logic [dq_pkg::DATA_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8)  return 32'h8000_0000;
      if (r < 16) return 32'h7fff_ffff;
      if (r < 20) return '0;
      if (r < 24) return '1;
      return $urandom;
   endfunction

   // Operation mix leaning toward growth, shrinkage or neither
   function automatic logic [dq_pkg::CODE_W-1:0] pick_op(bias_mode_type mode);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r >= 96) return dq_pkg::CODE_W'($urandom_range(OP_BAD_LO, OP_BAD_HI));
      if (r >= 88) return dq_pkg::OP_DUMP;
      case (mode)
         MODE_FILL: begin
            if (r < 38) return dq_pkg::OP_PUSH_FRONT;
            if (r < 76) return dq_pkg::OP_PUSH_REAR;
            if (r < 82) return dq_pkg::OP_POP_FRONT;
            return dq_pkg::OP_POP_REAR;
         end
         MODE_DRAIN: begin
            if (r < 38) return dq_pkg::OP_POP_FRONT;
            if (r < 76) return dq_pkg::OP_POP_REAR;
            if (r < 82) return dq_pkg::OP_PUSH_FRONT;
            return dq_pkg::OP_PUSH_REAR;
         end
         default: return dq_pkg::CODE_W'($urandom_range(dq_pkg::OP_PUSH_FRONT,
                                                        dq_pkg::OP_POP_REAR));
      endcase
   endfunction

   initial begin
      int unsigned   phase;
      bias_mode_type mode;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty cases, extremes, front push wrapping below slot 0,
      // unused codes, pops from both ends
      send_request(dq_pkg::OP_DUMP, '0);
      send_request(dq_pkg::OP_POP_FRONT, '1);
      send_request(dq_pkg::OP_POP_REAR, '1);
      send_request(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
      send_request(dq_pkg::OP_PUSH_REAR, 32'h7fff_ffff);
      send_request(dq_pkg::OP_PUSH_FRONT, '1);
      send_request(dq_pkg::OP_PUSH_REAR, '0);
      send_request(dq_pkg::OP_DUMP, 32'h5a5a_a5a5);
      send_request(OP_BAD_LO, $urandom);
      send_request(OP_BAD_MID, $urandom);
      send_request(OP_BAD_HI, $urandom);
      send_request(dq_pkg::OP_POP_FRONT, '0);
      send_request(dq_pkg::OP_DUMP, '0);
      send_request(dq_pkg::OP_POP_REAR, '0);
      send_request(dq_pkg::OP_POP_FRONT, '0);
      send_request(dq_pkg::OP_POP_REAR, '0);
      send_request(dq_pkg::OP_DUMP, '0);
      send_request(dq_pkg::OP_POP_REAR, '0);
      send_request(dq_pkg::OP_PUSH_REAR, 32'h0000_0001);
      send_request(dq_pkg::OP_POP_FRONT, '0);

      // Random phases: fill to overflow, drain to underflow, or mixed traffic
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         mode   = (phase < 3) ? bias_mode_type'(phase % 2)
                              : bias_mode_type'($urandom_range(MODE_FILL, MODE_MIXED));
         steady <= (phase == 2);
         case (mode)
            MODE_FILL: begin
               while (sb.fill < dq_pkg::DEPTH && items_sent < ITEM_TARGET)
                  send_request(pick_op(MODE_FILL), pick_value());
               send_request(dq_pkg::OP_PUSH_FRONT, pick_value());
               send_request(dq_pkg::OP_PUSH_REAR, pick_value());
               send_request(dq_pkg::OP_DUMP, pick_value());
            end
            MODE_DRAIN: begin
               while (sb.fill > 0 && items_sent < ITEM_TARGET)
                  send_request(pick_op(MODE_DRAIN), pick_value());
               send_request(dq_pkg::OP_POP_FRONT, pick_value());
               send_request(dq_pkg::OP_POP_REAR, pick_value());
               send_request(dq_pkg::OP_DUMP, pick_value());
            end
            default: begin
               repeat (MIXED_RUN)
                  if (items_sent < ITEM_TARGET)
                     send_request(pick_op(MODE_MIXED), pick_value());
            end
         endcase
         phase++;
      end
      req_tvalid <= 1'b0;
      steady     <= 1'b0;

      // Drain the remaining results, then allow late beats to show up
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/double_ended_queue.sv
tb/double_ended_queue_test.sv
